### design/fqsj_pkg.sv
// ----------------------------------------------------------------------------
// fqsj_pkg: shared types and constants of the flow QoS statistics engine
// Command codes, sequencer states, step indexes and the operand bundle of the
// shared add/subtract unit.
// ----------------------------------------------------------------------------
package fqsj_pkg;

  // Width of the shared arithmetic unit; time differences are formed at it.
  localparam int ALU_W  = 64;
  localparam int STEP_W = $clog2(ALU_W);

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    CMD_TX         = 3'd0,
    CMD_RX         = 3'd1,
    CMD_LOAD_DROP  = 3'd2,
    CMD_METER_DROP = 3'd3,
    CMD_SLICE_DROP = 3'd4,
    CMD_QUEUE_DROP = 3'd5,
    CMD_CLEAR      = 3'd6,
    CMD_QUERY      = 3'd7
  } cmd_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TX    = 8'b0000_0010,
    S_RX    = 8'b0000_0100,
    S_DROP  = 8'b0000_1000,
    S_CLEAR = 8'b0001_0000,
    S_QRY   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  // Operands of the shared unit: result = a + b, or a - b when sub is set.
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_op_t;

  // Transmit steps.
  localparam step_t TX_PKT   = step_t'(0);
  localparam step_t TX_BYTES = step_t'(1);

  // Receive steps.
  localparam step_t RX_ARR_GAP   = step_t'(0);
  localparam step_t RX_STAMP_GAP = step_t'(1);
  localparam step_t RX_DIFF      = step_t'(2);
  localparam step_t RX_MAG       = step_t'(3);
  localparam step_t RX_CMP       = step_t'(4);
  localparam step_t RX_JIT_A     = step_t'(5);
  localparam step_t RX_JIT_B     = step_t'(6);
  localparam step_t RX_PKT       = step_t'(7);
  localparam step_t RX_BYTES     = step_t'(8);
  localparam step_t RX_DELAY     = step_t'(9);
  localparam step_t RX_DELAY_SUM = step_t'(10);

  // Query steps.
  localparam step_t Q_LOST = step_t'(0);
  localparam step_t Q_SPAN = step_t'(1);
  localparam step_t Q_MAG  = step_t'(2);

  // Last divider iteration.
  localparam step_t DIV_LAST = step_t'(ALU_W - 1);

  // Jitter smoothing: gain of one sixteenth, rounded up when decreasing.
  localparam int JIT_SHIFT = 4;
  localparam int JIT_ROUND = 15;

endpackage

### design/flow_qos_stats_jitter.sv
// ----------------------------------------------------------------------------
// flow_qos_stats_jitter: per-flow QoS statistics with interarrival jitter
// Counts packets, bytes and drops of one flow, sums one-way delay, tracks the
// smoothed interarrival jitter, and returns a snapshot on a query.
// ----------------------------------------------------------------------------
// Usage
// Events enter on the input channel (in_valid_i / in_stall_o) and query
// snapshots leave on the output channel (out_valid_o / out_stall_i). A
// transfer happens at a rising edge with valid high and stall low. Only a
// query produces an output transfer; all other commands update state only.
// The block takes one event at a time and drives in_stall_o while it works.
// All arithmetic runs through one shared 64-bit add/subtract unit under a
// small sequencer, so the cost of an event is its number of unit steps. A
// new event is accepted only once the sequencer is back in idle.
// A query runs its lost, span and magnitude steps, then a restoring divider
// with one quotient bit per cycle over the 64-bit delay magnitude for the
// mean delay (skipped when nothing was received), then one final step that
// loads the output register. The result sits there, so events are accepted
// while it waits; only a second query's final step waits for the slot.
// Reset clears all counters, times, the jitter and the delay sum to zero.
// While the receiver stalls, the snapshot is held unchanged.
// ----------------------------------------------------------------------------
module flow_qos_stats_jitter
  import fqsj_pkg::*;
#(
  parameter int TIME_BITS  = 48,
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           cmd_i,
  input  logic [TIME_BITS-1:0] now_time_i,
  input  logic [15:0]          byte_count_i,
  input  logic [TIME_BITS-1:0] sent_time_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          tx_count_o,
  output logic [31:0]          tx_byte_total_o,
  output logic [31:0]          rx_count_o,
  output logic [31:0]          rx_byte_total_o,
  output logic [31:0]          lost_count_o,
  output logic [TIME_BITS:0]   active_span_o,
  output logic [TIME_BITS:0]   mean_delay_o,
  output logic [TIME_BITS-1:0] jitter_estimate_o,
  output logic [31:0]          load_drop_count_o,
  output logic [31:0]          meter_drop_count_o,
  output logic [31:0]          slice_drop_count_o,
  output logic [31:0]          queue_drop_count_o
);

  // The jitter state needs one bit more than a timestamp.
  localparam int JW = TIME_BITS + 1;
  localparam logic [ALU_W-1:0] LIM = ALU_W'(1) << TIME_BITS;

  state_e state_q, state_d;
  step_t  step_q, step_d;

  // Captured event.
  cmd_e                 cmd_q;
  logic [TIME_BITS-1:0] now_q;
  logic [15:0]          bytes_q;
  logic [TIME_BITS-1:0] stamp_q;

  // Flow statistics.
  logic [COUNT_BITS-1:0] tx_pkt_q, tx_byte_q, rx_pkt_q, rx_byte_q;
  logic [COUNT_BITS-1:0] drop_q [4];
  logic [TIME_BITS-1:0]  first_send_q, last_arr_q, last_stamp_q;
  logic [JW-1:0]         jitter_q;
  logic [ALU_W-1:0]      delay_q;

  // Working registers of the sequencer.
  logic [ALU_W-1:0]      tmp_q, tmp2_q;
  logic                  ge_q, neg_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [COUNT_BITS-1:0] lost_q;
  logic [TIME_BITS:0]    span_q;

  // Output register.
  logic                  out_valid_q;
  logic [31:0]           o_tx_q, o_txb_q, o_rx_q, o_rxb_q, o_lost_q;
  logic [31:0]           o_drop_q [4];
  logic [TIME_BITS:0]    o_span_q, o_mean_q;
  logic [TIME_BITS-1:0]  o_jit_q;

  logic                  in_xfer;
  logic                  out_load;
  logic [1:0]            drop_idx;
  logic [ALU_W-1:0]      q_sat;
  logic [COUNT_BITS:0]   div_part;

  // Shared add/subtract unit. For a subtraction, carry set means a >= b.
  alu_op_t               alu;
  logic [ALU_W:0]        alu_sum;
  logic [ALU_W-1:0]      alu_res;
  logic                  alu_carry;

  assign alu_sum   = {1'b0, alu.a} + {1'b0, alu.b ^ {ALU_W{alu.sub}}}
                   + (ALU_W + 1)'(alu.sub);
  assign alu_res   = alu_sum[ALU_W-1:0];
  assign alu_carry = alu_sum[ALU_W];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // Partial remainder of the restoring divider: next dividend bit shifted in.
  assign div_part = {rem_q, tmp_q[ALU_W-1]};

  always_comb begin
    case (cmd_q)
      CMD_LOAD_DROP:  drop_idx = 2'd0;
      CMD_METER_DROP: drop_idx = 2'd1;
      CMD_SLICE_DROP: drop_idx = 2'd2;
      CMD_QUEUE_DROP: drop_idx = 2'd3;
      default:        drop_idx = 2'd0;
    endcase
  end

  // Quotient magnitude clamped to the signed output range.
  always_comb begin
    q_sat = tmp_q;
    if (neg_q) begin
      if ((tmp_q >= LIM) && (tmp_q != LIM)) begin
        q_sat = LIM;
      end
    end else if (tmp_q >= LIM) begin
      q_sat = LIM - ALU_W'(1);
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu = '0;
    case (state_q)
      S_TX: begin
        if (step_q == TX_PKT) begin
          alu.a = ALU_W'(tx_pkt_q);
          alu.b = ALU_W'(1);
        end else begin
          alu.a = ALU_W'(tx_byte_q);
          alu.b = ALU_W'(bytes_q);
        end
      end
      S_RX: begin
        case (step_q)
          RX_ARR_GAP: begin
            alu.a = ALU_W'(now_q);
            alu.b = ALU_W'(last_arr_q);
            alu.sub = 1'b1;
          end
          RX_STAMP_GAP: begin
            alu.a = ALU_W'(stamp_q);
            alu.b = ALU_W'(last_stamp_q);
            alu.sub = 1'b1;
          end
          RX_DIFF: begin
            alu.a = tmp_q;
            alu.b = tmp2_q;
            alu.sub = 1'b1;
          end
          RX_MAG: begin
            alu.b = tmp_q;
            alu.sub = 1'b1;
          end
          RX_CMP: begin
            alu.a = tmp_q;
            alu.b = ALU_W'(jitter_q);
            alu.sub = 1'b1;
          end
          RX_JIT_A: begin
            if (ge_q) begin
              alu.a = ALU_W'(jitter_q);
              alu.b = tmp2_q >> JIT_SHIFT;
            end else begin
              alu.a = ALU_W'(JIT_ROUND);
              alu.b = tmp2_q;
              alu.sub = 1'b1;
            end
          end
          RX_JIT_B: begin
            alu.a = ALU_W'(jitter_q);
            alu.b = tmp2_q >> JIT_SHIFT;
            alu.sub = 1'b1;
          end
          RX_PKT: begin
            alu.a = ALU_W'(rx_pkt_q);
            alu.b = ALU_W'(1);
          end
          RX_BYTES: begin
            alu.a = ALU_W'(rx_byte_q);
            alu.b = ALU_W'(bytes_q);
          end
          RX_DELAY: begin
            alu.a = ALU_W'(now_q);
            alu.b = ALU_W'(stamp_q);
            alu.sub = 1'b1;
          end
          RX_DELAY_SUM: begin
            alu.a = delay_q;
            alu.b = tmp_q;
          end
          default: alu = '0;
        endcase
      end
      S_DROP: begin
        alu.a = ALU_W'(drop_q[drop_idx]);
        alu.b = ALU_W'(1);
      end
      S_QRY: begin
        case (step_q)
          Q_LOST: begin
            alu.a = ALU_W'(tx_pkt_q);
            alu.b = ALU_W'(rx_pkt_q);
            alu.sub = 1'b1;
          end
          Q_SPAN: begin
            alu.a = ALU_W'(last_arr_q);
            alu.b = ALU_W'(first_send_q);
            alu.sub = 1'b1;
          end
          default: begin
            alu.b = delay_q;
            alu.sub = 1'b1;
          end
        endcase
      end
      S_DIV: begin
        alu.a = ALU_W'(div_part);
        alu.b = ALU_W'(rx_pkt_q);
        alu.sub = 1'b1;
      end
      S_FIN: begin
        alu.b = q_sat;
        alu.sub = 1'b1;
      end
      default: alu = '0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    step_d  = step_q + step_t'(1);
    case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (in_xfer) begin
          case (cmd_e'(cmd_i))
            CMD_TX:    state_d = S_TX;
            CMD_RX:    state_d = S_RX;
            CMD_CLEAR: state_d = S_CLEAR;
            CMD_QUERY: state_d = S_QRY;
            default:   state_d = S_DROP;
          endcase
        end
      end
      S_TX: begin
        if (step_q == TX_BYTES) begin
          state_d = S_IDLE;
        end
      end
      S_RX: begin
        if (step_q == RX_DELAY_SUM) begin
          state_d = S_IDLE;
        end
      end
      S_QRY: begin
        if (step_q == Q_MAG) begin
          step_d  = '0;
          state_d = (rx_pkt_q != '0) ? S_DIV : S_FIN;
        end
      end
      S_DIV: begin
        if (step_q == DIV_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and flow statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      tx_pkt_q     <= '0;
      tx_byte_q    <= '0;
      rx_pkt_q     <= '0;
      rx_byte_q    <= '0;
      first_send_q <= '0;
      last_arr_q   <= '0;
      last_stamp_q <= '0;
      jitter_q     <= '0;
      delay_q      <= '0;
      for (int i = 0; i < 4; i++) begin
        drop_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_TX: begin
          if (step_q == TX_PKT) begin
            tx_pkt_q <= alu_res[COUNT_BITS-1:0];
            if (alu_res[COUNT_BITS-1:0] == COUNT_BITS'(1)) begin
              first_send_q <= now_q;
            end
          end else begin
            tx_byte_q <= alu_res[COUNT_BITS-1:0];
          end
        end
        S_RX: begin
          case (step_q)
            RX_JIT_A: begin
              if (ge_q) begin
                jitter_q <= alu_res[JW-1:0];
              end
            end
            RX_JIT_B: begin
              if (!ge_q) begin
                jitter_q <= alu_res[JW-1:0];
              end
            end
            RX_PKT:   rx_pkt_q  <= alu_res[COUNT_BITS-1:0];
            RX_BYTES: rx_byte_q <= alu_res[COUNT_BITS-1:0];
            RX_DELAY_SUM: begin
              delay_q      <= alu_res;
              last_arr_q   <= now_q;
              last_stamp_q <= stamp_q;
            end
            default: ;
          endcase
        end
        S_DROP: drop_q[drop_idx] <= alu_res[COUNT_BITS-1:0];
        S_CLEAR: begin
          tx_pkt_q     <= '0;
          tx_byte_q    <= '0;
          rx_pkt_q     <= '0;
          rx_byte_q    <= '0;
          first_send_q <= now_q;
          last_arr_q   <= now_q;
          last_stamp_q <= now_q;
          jitter_q     <= '0;
          delay_q      <= '0;
          for (int i = 0; i < 4; i++) begin
            drop_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Event capture, working registers and the output snapshot.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= cmd_e'(cmd_i);
      now_q   <= now_time_i;
      bytes_q <= byte_count_i;
      stamp_q <= sent_time_i;
    end
    case (state_q)
      S_RX: begin
        case (step_q)
          RX_ARR_GAP:   tmp_q  <= alu_res;
          RX_STAMP_GAP: tmp2_q <= alu_res;
          RX_DIFF:      tmp_q  <= alu_res;
          RX_MAG: begin
            if (tmp_q[ALU_W-1]) begin
              tmp_q <= alu_res;
            end
          end
          RX_CMP: begin
            tmp2_q <= alu_res;
            ge_q   <= alu_carry;
          end
          RX_JIT_A: begin
            if (!ge_q) begin
              tmp2_q <= alu_res;
            end
          end
          RX_DELAY: tmp_q <= alu_res;
          default: ;
        endcase
      end
      S_QRY: begin
        case (step_q)
          Q_LOST: begin
            lost_q <= ((tx_pkt_q != '0) && alu_carry) ? alu_res[COUNT_BITS-1:0] : '0;
          end
          Q_SPAN: begin
            span_q <= (rx_pkt_q != '0) ? alu_res[TIME_BITS:0] : '0;
          end
          default: begin
            neg_q <= delay_q[ALU_W-1];
            tmp_q <= delay_q[ALU_W-1] ? alu_res : delay_q;
            rem_q <= '0;
          end
        endcase
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle, MSB first.
        if (alu_carry) begin
          rem_q <= alu_res[COUNT_BITS-1:0];
        end else begin
          rem_q <= div_part[COUNT_BITS-1:0];
        end
        tmp_q <= {tmp_q[ALU_W-2:0], alu_carry};
      end
      default: ;
    endcase
    if (out_load) begin
      o_tx_q   <= 32'(tx_pkt_q);
      o_txb_q  <= 32'(tx_byte_q);
      o_rx_q   <= 32'(rx_pkt_q);
      o_rxb_q  <= 32'(rx_byte_q);
      o_lost_q <= 32'(lost_q);
      o_span_q <= span_q;
      o_mean_q <= neg_q ? alu_res[TIME_BITS:0] : q_sat[TIME_BITS:0];
      o_jit_q  <= jitter_q[JW-1] ? '1 : jitter_q[TIME_BITS-1:0];
      for (int i = 0; i < 4; i++) begin
        o_drop_q[i] <= 32'(drop_q[i]);
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign tx_count_o         = o_tx_q;
  assign tx_byte_total_o    = o_txb_q;
  assign rx_count_o         = o_rx_q;
  assign rx_byte_total_o    = o_rxb_q;
  assign lost_count_o       = o_lost_q;
  assign active_span_o      = o_span_q;
  assign mean_delay_o       = o_mean_q;
  assign jitter_estimate_o  = o_jit_q;
  assign load_drop_count_o  = o_drop_q[0];
  assign meter_drop_count_o = o_drop_q[1];
  assign slice_drop_count_o = o_drop_q[2];
  assign queue_drop_count_o = o_drop_q[3];

`ifndef SYNTH
  // A snapshot only ever appears out of the final query step.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("output transfer raised outside the query final step");

  // The jitter only moves on a receive or a clear.
  a_jitter_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RX && state_q != S_CLEAR) |=> $stable(jitter_q))
    else $error("jitter changed outside receive or clear");

  // The divider remainder stays below the divisor.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < rx_pkt_q))
    else $error("divider remainder not below receive count");

  // The query path is entered only for a query command.
  a_qry_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QRY || state_q == S_DIV || state_q == S_FIN) |-> (cmd_q == CMD_QUERY))
    else $error("query sequence running for another command");
`endif

endmodule

### verif/tb_flow_qos_stats_jitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flow_qos_stats_jitter: self-checking testbench of the flow QoS engine
// Sends event streams through the input channel and compares every query
// snapshot, field by field, against a cycle-free model of the counters, the
// delay sum and the interarrival jitter kept inside this testbench.
// ----------------------------------------------------------------------------
module tb_flow_qos_stats_jitter
  import fqsj_pkg::*;
();

  localparam int TB_TIME = 48;

  // The jitter filter moves one sixteenth of the error per receive.
  localparam int SMOOTH_SHIFT = 4;
  localparam logic [63:0] SMOOTH_ROUND = 64'd15;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] JITTER_CAP = 64'h0000_FFFF_FFFF_FFFF;

  // Receiver back-pressure styles, cycled through at random.
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_mode_e;

  // One expected query snapshot.
  typedef struct {
    logic [31:0] tx_count;
    logic [31:0] tx_bytes;
    logic [31:0] rx_count;
    logic [31:0] rx_bytes;
    logic [31:0] lost;
    logic [48:0] span;
    logic [48:0] mean;
    logic [47:0] jitter;
    logic [31:0] drops [4];
  } snapshot_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block. Every input starts at a
  // known value at time zero.
  // --------------------------------------------------------------------------
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [2:0]           cmd_i        = CMD_QUERY;
  logic [TB_TIME-1:0]   now_time_i   = '0;
  logic [15:0]          byte_count_i = '0;
  logic [TB_TIME-1:0]   sent_time_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [31:0]          tx_count_o;
  logic [31:0]          tx_byte_total_o;
  logic [31:0]          rx_count_o;
  logic [31:0]          rx_byte_total_o;
  logic [31:0]          lost_count_o;
  logic [TB_TIME:0]     active_span_o;
  logic [TB_TIME:0]     mean_delay_o;
  logic [TB_TIME-1:0]   jitter_estimate_o;
  logic [31:0]          load_drop_count_o;
  logic [31:0]          meter_drop_count_o;
  logic [31:0]          slice_drop_count_o;
  logic [31:0]          queue_drop_count_o;

  // 12 ns period, high half first after the initial low phase.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  flow_qos_stats_jitter dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .now_time_i         (now_time_i),
    .byte_count_i       (byte_count_i),
    .sent_time_i        (sent_time_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .tx_count_o         (tx_count_o),
    .tx_byte_total_o    (tx_byte_total_o),
    .rx_count_o         (rx_count_o),
    .rx_byte_total_o    (rx_byte_total_o),
    .lost_count_o       (lost_count_o),
    .active_span_o      (active_span_o),
    .mean_delay_o       (mean_delay_o),
    .jitter_estimate_o  (jitter_estimate_o),
    .load_drop_count_o  (load_drop_count_o),
    .meter_drop_count_o (meter_drop_count_o),
    .slice_drop_count_o (slice_drop_count_o),
    .queue_drop_count_o (queue_drop_count_o)
  );

  // --------------------------------------------------------------------------
  // Flow statistics model. It holds its own copy of every counter and time
  // register and is advanced once per accepted input transfer.
  // --------------------------------------------------------------------------
  logic [31:0] flow_tx_pkts, flow_tx_bytes, flow_rx_pkts, flow_rx_bytes;
  logic [47:0] flow_first_send, flow_last_arrival, flow_last_stamp;
  logic [63:0] flow_jitter;     // magnitude, never exceeds 49 bits
  logic [63:0] flow_delay_sum;  // two's complement, wraps at 64 bits
  logic [31:0] flow_drops [4];

  snapshot_t pending_snapshots [$];

  int unsigned error_count;
  int unsigned events_sent;
  int unsigned queries_sent;
  int unsigned snapshots_checked;

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [47:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  task automatic clear_flow(logic [47:0] now);
    flow_tx_pkts      = '0;
    flow_tx_bytes     = '0;
    flow_rx_pkts      = '0;
    flow_rx_bytes     = '0;
    flow_first_send   = now;
    flow_last_arrival = now;
    flow_last_stamp   = now;
    flow_jitter       = '0;
    flow_delay_sum    = '0;
    for (int i = 0; i < 4; i++) flow_drops[i] = '0;
  endtask

  // Mean one-way delay: truncated toward zero, held to the signed 49-bit
  // range. With nothing received the raw sum is reported.
  function automatic logic [48:0] mean_delay_of_flow();
    logic        neg;
    logic [63:0] q;
    logic [63:0] lim;
    neg = flow_delay_sum[63];
    q   = abs64(flow_delay_sum);
    lim = 64'd1 << TB_TIME;
    if (flow_rx_pkts != 0) q = q / {32'd0, flow_rx_pkts};
    if (neg) begin
      if (q > lim) q = lim;
      q = 64'd0 - q;
    end else if (q > lim - 64'd1) begin
      q = lim - 64'd1;
    end
    return q[48:0];
  endfunction

  // Advances the model by one event; a query queues the snapshot it expects.
  task automatic track_event(cmd_e op, logic [47:0] now, logic [15:0] bytes,
                             logic [47:0] stamp);
    logic [63:0] transit_diff;
    logic [63:0] mag;
    logic [63:0] span;
    snapshot_t   snap;
    case (op)
      CMD_TX: begin
        flow_tx_pkts  = flow_tx_pkts + 32'd1;
        flow_tx_bytes = flow_tx_bytes + {16'd0, bytes};
        // The first send time follows the counter landing on one.
        if (flow_tx_pkts == 32'd1) flow_first_send = now;
      end
      CMD_RX: begin
        // Difference of two transit times, formed exactly at 64 bits.
        transit_diff = ({16'd0, now} - {16'd0, flow_last_arrival}) -
                       ({16'd0, stamp} - {16'd0, flow_last_stamp});
        mag = abs64(transit_diff);
        flow_rx_pkts  = flow_rx_pkts + 32'd1;
        flow_rx_bytes = flow_rx_bytes + {16'd0, bytes};
        // Growing errors are truncated, shrinking ones rounded up, so the
        // estimate settles exactly on a constant input that lies below it.
        if (mag >= flow_jitter)
          flow_jitter = flow_jitter + ((mag - flow_jitter) >> SMOOTH_SHIFT);
        else
          flow_jitter = flow_jitter -
                        (((flow_jitter - mag) + SMOOTH_ROUND) >> SMOOTH_SHIFT);
        flow_last_arrival = now;
        flow_last_stamp   = stamp;
        flow_delay_sum    = flow_delay_sum + ({16'd0, now} - {16'd0, stamp});
      end
      CMD_LOAD_DROP:  flow_drops[0] = flow_drops[0] + 32'd1;
      CMD_METER_DROP: flow_drops[1] = flow_drops[1] + 32'd1;
      CMD_SLICE_DROP: flow_drops[2] = flow_drops[2] + 32'd1;
      CMD_QUEUE_DROP: flow_drops[3] = flow_drops[3] + 32'd1;
      CMD_CLEAR:      clear_flow(now);
      default: begin
        span = {16'd0, flow_last_arrival} - {16'd0, flow_first_send};
        snap.tx_count = flow_tx_pkts;
        snap.tx_bytes = flow_tx_bytes;
        snap.rx_count = flow_rx_pkts;
        snap.rx_bytes = flow_rx_bytes;
        snap.lost     = (flow_tx_pkts != 0 && flow_tx_pkts >= flow_rx_pkts) ?
                        flow_tx_pkts - flow_rx_pkts : 32'd0;
        snap.span     = (flow_rx_pkts != 0) ? span[48:0] : 49'd0;
        snap.mean     = mean_delay_of_flow();
        snap.jitter   = (flow_jitter > JITTER_CAP) ? TIME_MAX : flow_jitter[47:0];
        for (int i = 0; i < 4; i++) snap.drops[i] = flow_drops[i];
        pending_snapshots.push_back(snap);
        queries_sent++;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Reporting and the result checker. Each output transfer is matched with
  // the oldest snapshot still waiting. Every mismatch prints one line and is
  // counted.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("snapshot %0d %s: got 0x%0h, expected 0x%0h",
                                snapshots_checked, name, got, want));
  endtask

  snapshot_t oldest_snapshot;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_snapshots.size() == 0) begin
        report_mismatch("output transfer with no query outstanding");
      end else begin
        oldest_snapshot = pending_snapshots.pop_front();
        check_field("tx_count",        tx_count_o,         oldest_snapshot.tx_count);
        check_field("tx_byte_total",   tx_byte_total_o,    oldest_snapshot.tx_bytes);
        check_field("rx_count",        rx_count_o,         oldest_snapshot.rx_count);
        check_field("rx_byte_total",   rx_byte_total_o,    oldest_snapshot.rx_bytes);
        check_field("lost_count",      lost_count_o,       oldest_snapshot.lost);
        check_field("active_span",     active_span_o,      oldest_snapshot.span);
        check_field("mean_delay",      mean_delay_o,       oldest_snapshot.mean);
        check_field("jitter_estimate", jitter_estimate_o,  oldest_snapshot.jitter);
        check_field("load_drop",       load_drop_count_o,  oldest_snapshot.drops[0]);
        check_field("meter_drop",      meter_drop_count_o, oldest_snapshot.drops[1]);
        check_field("slice_drop",      slice_drop_count_o, oldest_snapshot.drops[2]);
        check_field("queue_drop",      queue_drop_count_o, oldest_snapshot.drops[3]);
        snapshots_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure. A mode is held for a random stretch of cycles:
  // no stall at all, sparse stalls, mostly stalled, or long runs of either
  // level. The stall changes on the falling edge like every other input.
  // --------------------------------------------------------------------------
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_phase_left = 0;
  int unsigned stall_run_left = 0;
  logic        stall_level = 1'b0;

  always @(negedge clk_i) begin
    if (stall_phase_left == 0) begin
      stall_mode       = stall_mode_e'($urandom_range(0, 3));
      stall_phase_left = $urandom_range(40, 300);
    end
    stall_phase_left--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run_left == 0) begin
          stall_level    = !stall_level;
          stall_run_left = $urandom_range(1, 40);
        end
        stall_run_left--;
        out_stall_i <= stall_level;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length; between bursts valid
  // drops for a random number of cycles, up to sender_gap_max. A gap of zero
  // keeps valid high, so a burst can run straight into the next one. The
  // payload is held while the block stalls, and the model is updated on the
  // edge where the transfer happens.
  // --------------------------------------------------------------------------
  int unsigned sender_gap_max = 8;
  int unsigned burst_left = 0;

  task automatic send_event(cmd_e op, logic [47:0] now, logic [15:0] bytes,
                            logic [47:0] stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, sender_gap_max);
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    cmd_i        <= op;
    now_time_i   <= now;
    byte_count_i <= bytes;
    sent_time_i  <= stamp;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_event(op, now, bytes, stamp);
    events_sent++;
    @(negedge clk_i);
  endtask

  // Drops valid and holds the sender off until every query has answered.
  task automatic wait_snapshots_drained();
    in_valid_i <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Right after reset every statistic reads zero.
  task automatic test_reset_state();
    send_event(CMD_QUERY, rand_time(), 16'($urandom), rand_time());
  endtask

  // Field extremes, every command, lost count with no and with too many
  // receives, negative delay with truncation toward zero, and clear.
  task automatic test_directed_extremes();
    send_event(CMD_TX, 48'd0, 16'hFFFF, 48'd0);
    send_event(CMD_TX, TIME_MAX, 16'h0000, TIME_MAX);
    send_event(CMD_TX, 48'h0000_1234_5678, 16'hFFFF, 48'd0);
    send_event(CMD_QUERY, 48'd0, 16'd0, 48'd0);
    // Largest positive one-way delay.
    send_event(CMD_RX, TIME_MAX, 16'hFFFF, 48'd0);
    send_event(CMD_QUERY, TIME_MAX, 16'hFFFF, TIME_MAX);
    // Largest negative one-way delay; the sender clock runs ahead.
    send_event(CMD_RX, 48'd0, 16'h0001, TIME_MAX);
    send_event(CMD_QUERY, 48'd0, 16'd0, 48'd0);
    send_event(CMD_LOAD_DROP, rand_time(), 16'hFFFF, TIME_MAX);
    send_event(CMD_LOAD_DROP, 48'd0, 16'd0, 48'd0);
    send_event(CMD_METER_DROP, TIME_MAX, 16'd0, 48'd0);
    send_event(CMD_SLICE_DROP, 48'd0, 16'hFFFF, TIME_MAX);
    send_event(CMD_QUEUE_DROP, rand_time(), 16'($urandom), rand_time());
    // More receives than transmits: nothing counts as lost.
    send_event(CMD_RX, 48'd500, 16'd64, 48'd400);
    send_event(CMD_RX, 48'd900, 16'd1500, 48'd750);
    send_event(CMD_QUERY, 48'd900, 16'd0, 48'd0);
    // Clear near the top of time, then two receives with stamps in the
    // future: the mean of -3 and -4 truncates to -3.
    send_event(CMD_CLEAR, TIME_MAX - 48'd100, 16'hFFFF, 48'd7);
    send_event(CMD_QUERY, 48'd0, 16'd0, 48'd0);
    send_event(CMD_RX, TIME_MAX - 48'd50, 16'd100, TIME_MAX - 48'd47);
    send_event(CMD_RX, TIME_MAX - 48'd20, 16'd200, TIME_MAX - 48'd16);
    send_event(CMD_QUERY, TIME_MAX, 16'd0, 48'd0);
  endtask

  // Receives alternating between the corners of time give, after the
  // first, a transit difference near 2^49 that drives the estimate past
  // the 48-bit output range. Two more receives lower it, not back into it.
  task automatic test_jitter_saturation();
    send_event(CMD_CLEAR, 48'd0, 16'd0, 48'd0);
    for (int i = 0; i < 14; i++) begin
      if (i % 2 == 0) send_event(CMD_RX, TIME_MAX, 16'($urandom), 48'd0);
      else            send_event(CMD_RX, 48'd0, 16'($urandom), TIME_MAX);
    end
    send_event(CMD_QUERY, 48'd0, 16'd0, 48'd0);
    send_event(CMD_RX, 48'd1000, 16'd64, 48'd1000);
    send_event(CMD_RX, 48'd2000, 16'd64, 48'd2000);
    send_event(CMD_QUERY, 48'd2000, 16'd0, 48'd0);
  endtask

  // Well-formed flow traffic: time moves forward, stamps trail it by a
  // delay drawn from the current profile, with drops, clears and queries in
  // between. About one item in eight is noise with every field random.
  logic [47:0] flow_now;
  logic [63:0] flow_base_delay;
  int unsigned flow_delay_spread;

  task automatic pick_delay_profile();
    case ($urandom_range(0, 2))
      0: begin
        flow_base_delay   = 64'($urandom_range(100, 2000));
        flow_delay_spread = $urandom_range(0, 300);
      end
      1: begin
        flow_base_delay   = {24'd0, $urandom, 8'($urandom)};
        flow_delay_spread = $urandom_range(0, 1_000_000);
      end
      default: begin
        flow_base_delay   = 64'd0 - 64'($urandom_range(1, 1000));
        flow_delay_spread = $urandom_range(0, 50);
      end
    endcase
  endtask

  task automatic test_random_traffic(int count);
    int unsigned pick;
    logic [63:0] stamp64;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_event(cmd_e'($urandom_range(0, 7)), rand_time(), 16'($urandom),
                   rand_time());
      end else begin
        flow_now = flow_now + 48'($urandom_range(1, 5000));
        pick = $urandom_range(0, 99);
        if (pick < 34) begin
          send_event(CMD_TX, flow_now, 16'($urandom), rand_time());
        end else if (pick < 68) begin
          stamp64 = {16'd0, flow_now} - flow_base_delay -
                    64'($urandom_range(0, flow_delay_spread));
          send_event(CMD_RX, flow_now, 16'($urandom), stamp64[47:0]);
        end else if (pick < 80) begin
          send_event(cmd_e'(CMD_LOAD_DROP + $urandom_range(0, 3)), flow_now,
                     16'($urandom), rand_time());
        end else if (pick < 96) begin
          send_event(CMD_QUERY, flow_now, 16'($urandom), rand_time());
        end else begin
          send_event(CMD_CLEAR, flow_now, 16'($urandom), rand_time());
          pick_delay_profile();
        end
      end
    end
  endtask

  // The sender stops after a query until every snapshot is back, then
  // stays quiet a little longer before traffic resumes.
  task automatic test_drain_pause();
    send_event(CMD_QUERY, flow_now, 16'd0, 48'd0);
    wait_snapshots_drained();
    repeat ($urandom_range(5, 40)) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_flow(48'd0);
    error_count       = 0;
    events_sent       = 0;
    queries_sent      = 0;
    snapshots_checked = 0;
    flow_now          = rand_time();
    pick_delay_profile();

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_directed_extremes();
    test_jitter_saturation();
    test_random_traffic(360);
    test_drain_pause();
    // Second half with the sender never idling between bursts.
    sender_gap_max = 0;
    test_random_traffic(330);

    // Let the last query finish, then watch long enough to catch a stray
    // output transfer from the divider path.
    wait_snapshots_drained();
    repeat (100) @(posedge clk_i);
    if (pending_snapshots.size() != 0)
      report_mismatch($sformatf("%0d snapshots never arrived",
                                pending_snapshots.size()));

    $display("Sent %0d events over all eight commands, %0d of them queries;",
             events_sent, queries_sent);
    $display("checked %0d snapshots under stalls on both channels, %0d errors.",
             snapshots_checked, error_count);
    if (error_count == 0) begin
      $display("flow_qos_stats_jitter test passed");
    end else begin
      $display("flow_qos_stats_jitter test failed");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timeout: %0d snapshots still outstanding", pending_snapshots.size());
    $display("flow_qos_stats_jitter test failed");
    $finish;
  end

endmodule

### flow_qos_stats_jitter.f
design/fqsj_pkg.sv
design/flow_qos_stats_jitter.sv
verif/tb_flow_qos_stats_jitter.sv
